### rtl/core/stp_pkg.sv
// Shared types and constants for the shadowed tick PWM generator.
package stp_pkg;

  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned DUTY_W   = 17;

  // Q1.16 duty, this value means fully on
  localparam logic [DUTY_W-1:0] DUTY_ONE = 17'd65536;

  localparam logic [PERIOD_W-1:0] RESET_PERIOD = 32'd1000;
  localparam logic [DUTY_W-1:0]   RESET_DUTY   = 17'd32768;
  localparam logic [63:0] RESET_PROD = 64'(RESET_PERIOD) * 64'(RESET_DUTY);
  localparam logic [PERIOD_W-1:0] RESET_ACTIVE = RESET_PROD[47:16];

  typedef enum logic [0:0] {
    REG_INITIAL_PERIOD = 1'b0,
    REG_INITIAL_DUTY   = 1'b1
  } stp_reg_t;

  typedef struct packed {
    logic                req_type;
    logic [PERIOD_W-1:0] new_period;
    logic [DUTY_W-1:0]   new_duty;
    logic                shadow_mode;
  } stp_req_t;

  typedef struct packed {
    logic pwm_level;
    logic period_start;
  } stp_res_t;

endpackage

### rtl/core/stp_times.sv
// Active time of a PWM period: clamped Q1.16 duty times period, truncated.
module stp_times (
  input  logic [stp_pkg::PERIOD_W-1:0] period,
  input  logic [stp_pkg::DUTY_W-1:0]   duty,
  output logic [stp_pkg::PERIOD_W-1:0] active
);
  import stp_pkg::*;

  logic [DUTY_W-1:0]          duty_clamped;
  logic [PERIOD_W+DUTY_W-1:0] prod;

  assign duty_clamped = (duty > DUTY_ONE) ? DUTY_ONE : duty;
  assign prod = {{DUTY_W{1'b0}}, period} * {{PERIOD_W{1'b0}}, duty_clamped};
  // duty never exceeds one, so the shifted product fits in the period width
  assign active = prod[PERIOD_W+15:16];

endmodule

### rtl/core/shadowed_tick_pwm.sv
// Top level: tick-driven PWM generator with shadowed period and duty updates.
// Each request (a tick or a period/duty update) returns one result with the
// output level after the request and a flag for a tick that began the active
// phase. Requests are taken one per cycle while the output side does not stall;
// each request passes through the request register and then the result
// register, and the state update between them has as its longest path the
// 32x17 active-time multiply.
// The request register and the result register let a new request enter while
// a finished result still waits. Writing either configuration register
// restarts the generator at the start of an active phase with those values.
module shadowed_tick_pwm (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  stp_pkg::stp_req_t            req,
  output logic                         res_valid,
  input  logic                         res_stall,
  output stp_pkg::stp_res_t            res,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [stp_pkg::PERIOD_W-1:0] cfg_wdata
);
  import stp_pkg::*;

  // request register
  logic     item_valid;
  stp_req_t item;
  logic     go;

  // configuration
  logic [PERIOD_W-1:0] reg_period;
  logic [DUTY_W-1:0]   reg_duty;

  // generator state
  logic                level, level_next;
  logic [PERIOD_W-1:0] elapsed, elapsed_next;
  logic [PERIOD_W-1:0] phase_length, phase_length_next;
  logic [PERIOD_W-1:0] period_now, period_now_next;
  logic [PERIOD_W-1:0] active_time, active_time_next;
  logic [PERIOD_W-1:0] pending_period, pending_period_next;
  logic [PERIOD_W-1:0] pending_active, pending_active_next;
  logic                deferred_flag, deferred_flag_next;
  logic                started;

  logic [PERIOD_W-1:0] elapsed_inc;
  logic [PERIOD_W-1:0] op_period;
  logic [DUTY_W-1:0]   op_duty;
  logic [PERIOD_W-1:0] op_active;

  assign go        = item_valid && (!res_valid || !res_stall);
  assign req_stall = item_valid && !go;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      item_valid <= 1'b1;
    end else if (go) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      item <= req;
    end
  end

  // share the multiplier between restart on a register write and updates
  always_comb begin
    op_period = item.new_period;
    op_duty   = item.new_duty;
    if (cfg_we) begin
      op_period = (cfg_index == REG_INITIAL_PERIOD) ? cfg_wdata : reg_period;
      op_duty   = (cfg_index == REG_INITIAL_DUTY) ? cfg_wdata[DUTY_W-1:0] : reg_duty;
    end
  end

  stp_times u_times (
    .period (op_period),
    .duty   (op_duty),
    .active (op_active)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_period <= RESET_PERIOD;
      reg_duty   <= RESET_DUTY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INITIAL_PERIOD: reg_period <= cfg_wdata;
        REG_INITIAL_DUTY:   reg_duty   <= cfg_wdata[DUTY_W-1:0];
        default:            reg_period <= reg_period;
      endcase
    end
  end

  assign elapsed_inc = elapsed + 32'd1;

  always_comb begin
    level_next          = level;
    elapsed_next        = elapsed;
    phase_length_next   = phase_length;
    period_now_next     = period_now;
    active_time_next    = active_time;
    pending_period_next = pending_period;
    pending_active_next = pending_active;
    deferred_flag_next  = deferred_flag;
    started             = 1'b0;
    priority if (cfg_we) begin
      // restart as after reset with the written values
      level_next          = 1'b1;
      elapsed_next        = '0;
      phase_length_next   = op_active;
      period_now_next     = op_period;
      active_time_next    = op_active;
      pending_period_next = op_period;
      pending_active_next = op_active;
      deferred_flag_next  = 1'b0;
    end else if (go && item.req_type) begin
      deferred_flag_next  = item.shadow_mode;
      pending_period_next = op_period;
      pending_active_next = op_active;
      if (!item.shadow_mode) begin
        // running phase keeps its length; new times apply from the next toggle
        period_now_next  = op_period;
        active_time_next = op_active;
      end
    end else if (go) begin
      elapsed_next = elapsed_inc;
      if (elapsed_inc >= phase_length) begin
        elapsed_next = elapsed_inc - phase_length;
        if (level) begin
          level_next        = 1'b0;
          phase_length_next = period_now - active_time;
        end else begin
          level_next = 1'b1;
          started    = 1'b1;
          if (deferred_flag) begin
            period_now_next   = pending_period;
            active_time_next  = pending_active;
            phase_length_next = pending_active;
          end else begin
            phase_length_next = active_time;
          end
        end
      end
    end else begin
      started = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level          <= 1'b1;
      elapsed        <= '0;
      phase_length   <= RESET_ACTIVE;
      period_now     <= RESET_PERIOD;
      active_time    <= RESET_ACTIVE;
      pending_period <= RESET_PERIOD;
      pending_active <= RESET_ACTIVE;
      deferred_flag  <= 1'b0;
    end else begin
      level          <= level_next;
      elapsed        <= elapsed_next;
      phase_length   <= phase_length_next;
      period_now     <= period_now_next;
      active_time    <= active_time_next;
      pending_period <= pending_period_next;
      pending_active <= pending_active_next;
      deferred_flag  <= deferred_flag_next;
    end
  end

  // result register: load on every processed request, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (go) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res.pwm_level    <= level_next;
      res.period_start <= started;
    end
  end

  a_start_is_high: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!res.period_start || res.pwm_level))
    else $error("period start reported with output low");

  a_update_keeps_level: assert property (@(posedge clk) disable iff (rst)
    (go && item.req_type && !cfg_we) |=> (level == $past(level)))
    else $error("update changed the output level");

  a_start_on_rise: assert property (@(posedge clk) disable iff (rst)
    (go && started) |=> (level && !$past(level)))
    else $error("period start without a rise of the level");

  a_item_held: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !go) |=> (item_valid && $stable(item)))
    else $error("waiting request lost or changed");

endmodule
